// ===== rtl/core/phs_pkg.sv =====
// Phong shading intensity: shared types and constants.
// Holds the pipeline word struct, register indexes and fixed-point constants.
// No dependencies.
`default_nettype none

package phs_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_VIEW_X     = 3'd0;
    localparam logic [2:0] CFG_VIEW_Y     = 3'd1;
    localparam logic [2:0] CFG_VIEW_Z     = 3'd2;
    localparam logic [2:0] CFG_AMBIENT    = 3'd3;
    localparam logic [2:0] CFG_DIFFUSE    = 3'd4;
    localparam logic [2:0] CFG_SPECULAR   = 3'd5;
    localparam logic [2:0] CFG_SPEC_EXP   = 3'd6;

    // Command codes
    localparam logic CMD_TABLE_WRITE = 1'b0;
    localparam logic CMD_SHADE       = 1'b1;

    // Fixed-point constants
    localparam logic [15:0] Q15_ONE   = 16'h8000;
    localparam logic [15:0] SHADE_MAX = 16'hFFFF;

    // One power step per stage covers the largest 6-bit exponent
    localparam int POW_STAGES = 63;

    // Register reset values
    localparam logic [15:0] RST_VIEW_X   = 16'd0;
    localparam logic [15:0] RST_VIEW_Y   = 16'd0;
    localparam logic [15:0] RST_VIEW_Z   = 16'd16384;
    localparam logic [15:0] RST_AMBIENT  = 16'd3277;
    localparam logic [15:0] RST_DIFFUSE  = 16'd22938;
    localparam logic [15:0] RST_SPECULAR = 16'd6554;
    localparam logic [5:0]  RST_SPEC_EXP = 6'd10;

    // Word carried from the front end through the power chain
    typedef struct packed {
        logic        lit;   // cosine positive
        logic [15:0] kdc;   // (kd * c) >> 15
        logic [15:0] att;   // attenuation for this hit
        logic [15:0] base;  // specular base, 0 when not positive
        logic [15:0] spec;  // running specular power
        logic [5:0]  rem;   // power steps still to apply
    } t_hit;

endpackage

`default_nettype wire

// ===== rtl/core/phs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the depth attenuation table. No dependencies.
`default_nettype none

module phs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/phs_front.sv =====
// Front end: dot product, cosine, diffuse product, specular base, table access.
// Five register stages; depends on phs_pkg and phs_ram.
`default_nettype none

module phs_front
    import phs_pkg::*;
#(
    parameter int DIST_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_accept,
    input  wire logic               i_cmd,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    input  wire logic        [9:0]  i_distance_index,
    input  wire logic        [15:0] i_table_value,
    input  wire logic signed [15:0] i_view_x,
    input  wire logic signed [15:0] i_view_y,
    input  wire logic signed [15:0] i_view_z,
    input  wire logic        [15:0] i_diffuse_gain,
    input  wire logic        [5:0]  i_spec_exp,
    output logic                    o_valid,
    output t_hit                    o_hit
);

    localparam int ADDR_W = $clog2(DIST_DEPTH);

    logic               w_in_range;
    logic               w_we;
    logic [ADDR_W-1:0]  w_addr;
    logic [15:0]        w_rdata;

    // Stage 1: component products
    logic               r_v1;
    logic               r_in1;
    logic signed [31:0] r_px1, r_py1, r_pz1;
    // Stage 2: dot product and attenuation
    logic               r_v2;
    logic signed [33:0] r_dot2;
    logic [15:0]        r_att2;
    // Stage 3: cosine
    logic               r_v3;
    logic               r_lit3;
    logic [15:0]        r_c3;
    logic [15:0]        r_att3;
    // Stage 4: c squared and diffuse term
    logic               r_v4;
    logic               r_lit4;
    logic [31:0]        r_cc4;
    logic [15:0]        r_kdc4;
    logic [15:0]        r_att4;
    // Stage 5: specular base
    logic               r_v5;
    t_hit               r_hit5;

    logic [33:0]        n_dot;
    logic [20:0]        n_craw;
    logic [15:0]        n_c;
    logic               n_lit;
    logic [31:0]        n_kd_prod;
    logic [17:0]        n_base2;
    t_hit               n_hit;

    // Table write and read are both issued as the word enters
    assign w_in_range = 32'(i_distance_index) < DIST_DEPTH;
    assign w_addr     = ADDR_W'(i_distance_index);
    assign w_we       = i_accept && (i_cmd == CMD_TABLE_WRITE) && w_in_range;

    phs_ram #(
        .WIDTH (16),
        .DEPTH (DIST_DEPTH)
    ) u_att_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (i_table_value),
        .i_re    (i_en),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Combinational terms between stages
    always_comb begin
        n_dot     = 34'(r_px1) + 34'(r_py1) + 34'(r_pz1);
        n_craw    = r_dot2[33:13];
        n_c       = (n_craw > 21'(Q15_ONE)) ? Q15_ONE : n_craw[15:0];
        n_lit     = (r_dot2 > 34'sd0) && (n_c != 16'd0);
        n_kd_prod = i_diffuse_gain * r_c3;
        n_base2   = {r_cc4[31:15], 1'b0};
        n_hit.lit = r_lit4;
        n_hit.kdc = r_kdc4;
        n_hit.att = r_att4;
        n_hit.rem = i_spec_exp;
        if (n_base2 > 18'(Q15_ONE)) begin
            n_hit.base = 16'(n_base2 - 18'(Q15_ONE));
            n_hit.spec = Q15_ONE;
        end else begin
            n_hit.base = 16'd0;
            n_hit.spec = 16'd0;
        end
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_accept && (i_cmd == CMD_SHADE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Payload stages, held on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in1  <= w_in_range;
            r_px1  <= i_normal_x * i_view_x;
            r_py1  <= i_normal_y * i_view_y;
            r_pz1  <= i_normal_z * i_view_z;

            r_dot2 <= $signed(n_dot);
            r_att2 <= r_in1 ? w_rdata : 16'd0;

            r_c3   <= n_c;
            r_lit3 <= n_lit;
            r_att3 <= r_att2;

            r_cc4  <= r_c3 * r_c3;
            r_kdc4 <= n_kd_prod[30:15];
            r_lit4 <= r_lit3;
            r_att4 <= r_att3;

            r_hit5 <= n_hit;
        end
    end

    assign o_valid = r_v5;
    assign o_hit   = r_hit5;

endmodule

`default_nettype wire

// ===== rtl/core/phs_pow_stage.sv =====
// One step of the specular power chain: multiply by the base while steps remain.
// Depends on phs_pkg.
`default_nettype none

module phs_pow_stage
    import phs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  t_hit      i_hit,
    output logic      o_valid,
    output t_hit      o_hit
);

    logic        r_valid;
    t_hit        r_hit;
    logic [31:0] n_prod;
    t_hit        n_hit;

    // Apply one truncating multiply, or pass through once the count is spent
    always_comb begin
        n_prod = i_hit.spec * i_hit.base;
        n_hit  = i_hit;
        if (i_hit.rem != 6'd0) begin
            n_hit.spec = n_prod[30:15];
            n_hit.rem  = i_hit.rem - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

// ===== rtl/core/phs_back.sv =====
// Back end: specular product, term sum, attenuation, ambient add and saturation.
// Four register stages ending in the output register; depends on phs_pkg.
`default_nettype none

module phs_back
    import phs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  t_hit             i_hit,
    input  wire logic [15:0] i_ambient_gain,
    input  wire logic [15:0] i_specular_gain,
    output logic             o_valid,
    output logic      [15:0] o_shade,
    output logic             o_facing
);

    // Stage A: specular term
    logic        r_va, r_lita;
    logic [15:0] r_kdca, r_ksa, r_atta;
    // Stage B: term sum
    logic        r_vb, r_litb;
    logic [16:0] r_sumb;
    logic [15:0] r_attb;
    // Stage C: attenuated sum
    logic        r_vc, r_litc;
    logic [32:0] r_prodc;
    // Stage D: output register
    logic        r_vd;
    logic [15:0] r_shade;
    logic        r_facing;

    logic [31:0] n_ks_prod;
    logic [18:0] n_total;
    logic [15:0] n_shade;

    always_comb begin
        n_ks_prod = i_specular_gain * i_hit.spec;
        n_total   = 19'(i_ambient_gain) + 19'(r_prodc[32:15]);
        if (!r_litc) begin
            n_shade = 16'd0;
        end else if (n_total > 19'(SHADE_MAX)) begin
            n_shade = SHADE_MAX;
        end else begin
            n_shade = n_total[15:0];
        end
    end

    // Valid bits advance with the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    // Payload stages, held on stall
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ksa    <= n_ks_prod[30:15];
            r_kdca   <= i_hit.kdc;
            r_atta   <= i_hit.att;
            r_lita   <= i_hit.lit;

            r_sumb   <= 17'(r_kdca) + 17'(r_ksa);
            r_attb   <= r_atta;
            r_litb   <= r_lita;

            r_prodc  <= r_attb * r_sumb;
            r_litc   <= r_litb;

            r_shade  <= n_shade;
            r_facing <= r_litc;
        end
    end

    assign o_valid  = r_vd;
    assign o_shade  = r_shade;
    assign o_facing = r_facing;

endmodule

`default_nettype wire

// ===== rtl/core/phong_shading_intensity_top.sv =====
// Phong shading intensity, top level. Pipeline: 72 register stages (5 front,
// 63 power, 4 back), the last being the output register. Throughput: one word
// per cycle; the whole pipeline holds while the output word waits. Table-write
// words give no output. Reset (sync, active low) clears all valid bits and loads
// the register defaults; the attenuation table is not cleared. Depends on
// phs_pkg, phs_front/pow_stage/back.
`default_nettype none

module phong_shading_intensity_top
    import phs_pkg::*;
#(
    parameter int DIST_DEPTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_idx,
    input  wire logic        [15:0] i_cfg_wdata,
    // Input channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_cmd,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    input  wire logic        [9:0]  i_distance_index,
    input  wire logic        [15:0] i_table_value,
    // Output channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic             [15:0] o_shade,
    output logic                    o_facing
);

    logic signed [15:0] r_vx, r_vy, r_vz;
    logic [15:0] r_ambient, r_diffuse, r_specular;
    logic [5:0]  r_spec_exp;

    logic        w_en;
    logic        w_accept;
    logic        w_front_valid;
    t_hit        w_front_hit;
    logic        w_pow_valid [POW_STAGES+1];
    t_hit        w_pow_hit   [POW_STAGES+1];

    // Advance the pipeline unless the output word is stalled
    assign w_en     = !o_valid || i_ready;
    assign o_ready  = w_en;
    assign w_accept = i_valid && w_en;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vx       <= RST_VIEW_X;
            r_vy       <= RST_VIEW_Y;
            r_vz       <= RST_VIEW_Z;
            r_ambient  <= RST_AMBIENT;
            r_diffuse  <= RST_DIFFUSE;
            r_specular <= RST_SPECULAR;
            r_spec_exp <= RST_SPEC_EXP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEW_X:   r_vx       <= i_cfg_wdata;
                CFG_VIEW_Y:   r_vy       <= i_cfg_wdata;
                CFG_VIEW_Z:   r_vz       <= i_cfg_wdata;
                CFG_AMBIENT:  r_ambient  <= i_cfg_wdata;
                CFG_DIFFUSE:  r_diffuse  <= i_cfg_wdata;
                CFG_SPECULAR: r_specular <= i_cfg_wdata;
                CFG_SPEC_EXP: r_spec_exp <= i_cfg_wdata[5:0];
                default: begin
                end
            endcase
        end
    end

    phs_front #(
        .DIST_DEPTH (DIST_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (w_en),
        .i_accept         (w_accept),
        .i_cmd            (i_cmd),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_distance_index (i_distance_index),
        .i_table_value    (i_table_value),
        .i_view_x         (r_vx),
        .i_view_y         (r_vy),
        .i_view_z         (r_vz),
        .i_diffuse_gain   (r_diffuse),
        .i_spec_exp       (r_spec_exp),
        .o_valid          (w_front_valid),
        .o_hit            (w_front_hit)
    );

    // Specular power chain, one multiply per stage
    assign w_pow_valid[0] = w_front_valid;
    assign w_pow_hit[0]   = w_front_hit;

    for (genvar g = 0; g < POW_STAGES; g++) begin : g_pow
        phs_pow_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_pow_valid[g]),
            .i_hit   (w_pow_hit[g]),
            .o_valid (w_pow_valid[g+1]),
            .o_hit   (w_pow_hit[g+1])
        );
    end

    phs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (w_pow_valid[POW_STAGES]),
        .i_hit           (w_pow_hit[POW_STAGES]),
        .i_ambient_gain  (r_ambient),
        .i_specular_gain (r_specular),
        .o_valid         (o_valid),
        .o_shade         (o_shade),
        .o_facing        (o_facing)
    );

endmodule

`default_nettype wire

// ===== rtl/core/phs_checker.sv =====
// Port-level checks for the Phong shading intensity top level, with bind.
// Depends on phong_shading_intensity_top.
`default_nettype none

module phs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [15:0] o_shade,
    input wire logic        o_facing
);

    // A stalled output word holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_shade) && $stable(o_facing))
        else $error("output word changed while stalled");

    // An unlit hit always reads as zero brightness
    a_unlit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_facing |-> o_shade == 16'd0)
        else $error("unlit word with nonzero shade");

    // The input side stops exactly when the output word is stalled
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input ready does not follow output stall");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind phong_shading_intensity_top phs_checker u_phs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_shade  (o_shade),
    .o_facing (o_facing)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for phong_shading_intensity_top: directed table, then random phases.
// Predicts shade and facing bits in-line and checks every output word. Depends on phs_pkg.

module testbench;
    import phs_pkg::*;

    localparam int DIST_DEPTH      = 1024;
    localparam int CLK_HALF        = 4;
    localparam int PIPE_LATENCY    = 72;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 130;
    localparam int RUN_LIMIT_NS    = 5_000_000;

    // Register index with no register behind it
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    typedef struct packed {
        logic [15:0] shade;
        logic        facing;
    } t_shade_out;

    typedef enum logic {ROW_WORD, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic               cmd;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic        [9:0]  di;
        logic        [15:0] tv;
        logic        [2:0]  ridx;
        logic        [15:0] rval;
        logic               known;
        t_shade_out         want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic        [2:0]  i_cfg_idx;
    logic        [15:0] i_cfg_wdata;
    logic               i_valid;
    logic               o_ready;
    logic               i_cmd;
    logic signed [15:0] i_normal_x;
    logic signed [15:0] i_normal_y;
    logic signed [15:0] i_normal_z;
    logic        [9:0]  i_distance_index;
    logic        [15:0] i_table_value;
    logic               o_valid;
    logic               i_ready;
    logic        [15:0] o_shade;
    logic               o_facing;

    // Shadow copy of the register file and the attenuation table
    logic signed [15:0] cfg_view_x   = RST_VIEW_X;
    logic signed [15:0] cfg_view_y   = RST_VIEW_Y;
    logic signed [15:0] cfg_view_z   = RST_VIEW_Z;
    logic        [15:0] cfg_ambient  = RST_AMBIENT;
    logic        [15:0] cfg_diffuse  = RST_DIFFUSE;
    logic        [15:0] cfg_specular = RST_SPECULAR;
    logic        [5:0]  cfg_spec_exp = RST_SPEC_EXP;
    logic        [15:0] att_tbl [DIST_DEPTH];
    bit                 written [DIST_DEPTH];
    logic        [9:0]  written_list [$];

    t_shade_out  pending_shades [$];
    t_shade_out  got;
    t_plan_row   plan [$];
    int unsigned fail_count = 0;
    int unsigned ready_hold = 0;
    bit          tx_quiet = 1'b0;
    bit          rx_quiet = 1'b0;

    phong_shading_intensity_top #(
        .DIST_DEPTH (DIST_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_normal_x       (i_normal_x),
        .i_normal_y       (i_normal_y),
        .i_normal_z       (i_normal_z),
        .i_distance_index (i_distance_index),
        .i_table_value    (i_table_value),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_shade          (o_shade),
        .o_facing         (o_facing)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Mostly no gap, some short gaps, a few long ones
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned roll;
        roll = $urandom_range(99);
        if (quiet || roll < 65) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Brightness of one hit under the current registers and table
    function automatic t_shade_out phong_shade(input logic signed [15:0] nx, ny, nz,
                                               input logic [9:0] di);
        longint     dot, cosv, base, spec, sum, total;
        int         k;
        t_shade_out res;
        res = '0;
        dot = longint'(nx) * longint'(cfg_view_x) + longint'(ny) * longint'(cfg_view_y)
            + longint'(nz) * longint'(cfg_view_z);
        if (dot <= 0) return res;
        cosv = dot >> 13;
        if (cosv > longint'(Q15_ONE)) cosv = longint'(Q15_ONE);
        if (cosv == 0) return res;
        // Specular base 2c^2-1, raised to the exponent only when positive
        base = 2 * ((cosv * cosv) >> 15);
        if (base > longint'(Q15_ONE)) begin
            base = base - longint'(Q15_ONE);
            spec = longint'(Q15_ONE);
            for (k = 0; k < int'(cfg_spec_exp); k++) spec = (spec * base) >> 15;
        end else begin
            spec = 0;
        end
        sum = ((longint'(cfg_diffuse) * cosv) >> 15) + ((longint'(cfg_specular) * spec) >> 15);
        total = longint'(cfg_ambient) + ((longint'(att_tbl[di]) * sum) >> 15);
        if (total > longint'(SHADE_MAX)) total = longint'(SHADE_MAX);
        res.shade  = total[15:0];
        res.facing = 1'b1;
        return res;
    endfunction

    function automatic logic [15:0] jitter(input int center, input int spread);
        int v;
        v = center + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [15:0] gain_setting();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return Q15_ONE;
            2: return 16'($urandom());
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic [15:0] view_setting(input real frac);
        if ($urandom_range(9) == 0) return 16'($urandom());
        return 16'(int'(frac * 16384.0));
    endfunction

    function automatic t_plan_row row_write(input logic [9:0] di, input logic [15:0] tv);
        t_plan_row r;
        r = '0;
        r.kind = ROW_WORD;
        r.cmd  = CMD_TABLE_WRITE;
        r.di   = di;
        r.tv   = tv;
        return r;
    endfunction

    function automatic t_plan_row row_shade(input logic signed [15:0] nx, ny, nz,
                                            input logic [9:0] di);
        t_plan_row r;
        r = '0;
        r.kind = ROW_WORD;
        r.cmd  = CMD_SHADE;
        r.nx   = nx;
        r.ny   = ny;
        r.nz   = nz;
        r.di   = di;
        return r;
    endfunction

    function automatic t_plan_row row_known(input logic signed [15:0] nx, ny, nz,
                                            input logic [9:0] di, input logic [15:0] shade,
                                            input logic facing);
        t_plan_row r;
        r = row_shade(nx, ny, nz, di);
        r.known       = 1'b1;
        r.want.shade  = shade;
        r.want.facing = facing;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input logic [2:0] ridx, input logic [15:0] rval);
        t_plan_row r;
        r = '0;
        r.kind = ROW_REG;
        r.ridx = ridx;
        r.rval = rval;
        return r;
    endfunction

    // Drop valid, drain every expected word, then let the table-write tail settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_shades.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] ridx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= ridx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (ridx)
            CFG_VIEW_X:   cfg_view_x   = val;
            CFG_VIEW_Y:   cfg_view_y   = val;
            CFG_VIEW_Z:   cfg_view_z   = val;
            CFG_AMBIENT:  cfg_ambient  = val;
            CFG_DIFFUSE:  cfg_diffuse  = val;
            CFG_SPECULAR: cfg_specular = val;
            CFG_SPEC_EXP: cfg_spec_exp = val[5:0];
            default: ;
        endcase
    endtask

    // Offer one word, hold it until accepted, then record its effect
    task automatic send_word(input logic cmd, input logic signed [15:0] nx, ny, nz,
                             input logic [9:0] di, input logic [15:0] tv,
                             input logic known, input t_shade_out want);
        int unsigned gap;
        gap = pick_gap(tx_quiet);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_cmd            <= cmd;
        i_normal_x       <= nx;
        i_normal_y       <= ny;
        i_normal_z       <= nz;
        i_distance_index <= di;
        i_table_value    <= tv;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (cmd == CMD_TABLE_WRITE) begin
            att_tbl[di] = tv;
            if (!written[di]) begin
                written[di] = 1'b1;
                written_list.push_back(di);
            end
        end else if (known) begin
            pending_shades.push_back(want);
        end else begin
            pending_shades.push_back(phong_shade(nx, ny, nz, di));
        end
    endtask

    // Load all registers: low corner, high corner, or a random unit view
    task automatic configure_phase(input int unsigned phase);
        real         ax, ay, az, span;
        logic [15:0] exp_val;
        wait_idle();
        if (phase == 0) begin
            write_reg(CFG_VIEW_X, 16'(-16384));
            write_reg(CFG_VIEW_Y, 16'(-16384));
            write_reg(CFG_VIEW_Z, 16'(-16384));
            write_reg(CFG_AMBIENT, 16'd0);
            write_reg(CFG_DIFFUSE, 16'd0);
            write_reg(CFG_SPECULAR, 16'd0);
            write_reg(CFG_SPEC_EXP, 16'd0);
        end else if (phase == 1) begin
            write_reg(CFG_VIEW_X, 16'd16384);
            write_reg(CFG_VIEW_Y, 16'd16384);
            write_reg(CFG_VIEW_Z, 16'd16384);
            write_reg(CFG_AMBIENT, Q15_ONE);
            write_reg(CFG_DIFFUSE, Q15_ONE);
            write_reg(CFG_SPECULAR, Q15_ONE);
            write_reg(CFG_SPEC_EXP, 16'd63);
        end else begin
            ax = real'($urandom_range(32768)) - 16384.0;
            ay = real'($urandom_range(32768)) - 16384.0;
            az = real'($urandom_range(32768)) - 16384.0;
            span = $sqrt(ax * ax + ay * ay + az * az);
            if (span < 1.0) begin
                ax   = 1.0;
                span = 1.0;
            end
            write_reg(CFG_VIEW_X, view_setting(ax / span));
            write_reg(CFG_VIEW_Y, view_setting(ay / span));
            write_reg(CFG_VIEW_Z, view_setting(az / span));
            write_reg(CFG_AMBIENT, gain_setting());
            write_reg(CFG_DIFFUSE, gain_setting());
            write_reg(CFG_SPECULAR, gain_setting());
            case ($urandom_range(5))
                0: exp_val = 16'($urandom());
                1: exp_val = 16'($urandom_range(63));
                default: exp_val = 16'($urandom_range(12));
            endcase
            write_reg(CFG_SPEC_EXP, exp_val);
        end
    endtask

    // Mostly hits near the view direction; the rest is noise and table writes
    task automatic random_word();
        int unsigned        pick;
        int                 spread;
        logic signed [15:0] nx, ny, nz;
        logic        [15:0] tv;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(4))
                0: tv = 16'd0;
                1: tv = Q15_ONE;
                2: tv = 16'($urandom());
                default: tv = 16'($urandom_range(32768));
            endcase
            send_word(CMD_TABLE_WRITE, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                      10'($urandom_range(DIST_DEPTH - 1)), tv, 1'b0, '0);
        end else begin
            if (pick < 70) begin
                case ($urandom_range(3))
                    0: spread = 0;
                    1: spread = 256;
                    2: spread = 2048;
                    default: spread = 8192;
                endcase
                nx = jitter(cfg_view_x, spread);
                ny = jitter(cfg_view_y, spread);
                nz = jitter(cfg_view_z, spread);
            end else if (pick < 85) begin
                nx = 16'(int'($urandom_range(32768)) - 16384);
                ny = 16'(int'($urandom_range(32768)) - 16384);
                nz = 16'(int'($urandom_range(32768)) - 16384);
            end else if (pick < 93) begin
                nx = 16'($urandom());
                ny = 16'($urandom());
                nz = 16'($urandom());
            end else begin
                nx = jitter(-int'(cfg_view_x), 512);
                ny = jitter(-int'(cfg_view_y), 512);
                nz = jitter(-int'(cfg_view_z), 512);
            end
            send_word(CMD_SHADE, nx, ny, nz,
                      written_list[$urandom_range(written_list.size() - 1)],
                      16'($urandom()), 1'b0, '0);
        end
    endtask

    // Output side: check each accepted word, then stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            ready_hold <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (pending_shades.size() == 0) begin
                    $error("unexpected output word: shade %0d facing %0d", o_shade, o_facing);
                    fail_count++;
                end else begin
                    got = pending_shades.pop_front();
                    if (o_shade !== got.shade) begin
                        $error("shade mismatch: expected %0d, actual %0d", got.shade, o_shade);
                        fail_count++;
                    end
                    if (o_facing !== got.facing) begin
                        $error("facing mismatch: expected %0d, actual %0d",
                               got.facing, o_facing);
                        fail_count++;
                    end
                end
            end
            if (ready_hold != 0) begin
                ready_hold <= ready_hold - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready    <= 1'b1;
                ready_hold <= pick_gap(rx_quiet);
            end
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_wdata      = '0;
        i_valid          = 1'b0;
        i_cmd            = CMD_TABLE_WRITE;
        i_normal_x       = '0;
        i_normal_y       = '0;
        i_normal_z       = '0;
        i_distance_index = '0;
        i_table_value    = '0;
        i_ready          = 1'b0;

        // Table entries used by the directed hits
        plan.push_back(row_write(0, Q15_ONE));
        plan.push_back(row_write(1023, 16'hFFFF));
        plan.push_back(row_write(5, 16'd0));
        // Not facing: cosine negative, zero, orthogonal
        plan.push_back(row_known(0, 0, -16384, 0, 16'd0, 1'b0));
        plan.push_back(row_known(0, 0, 0, 0, 16'd0, 1'b0));
        plan.push_back(row_known(16384, 16384, 0, 0, 16'd0, 1'b0));
        // Normal along the view at full attenuation gives ka + kd + ks
        plan.push_back(row_known(0, 0, 16384, 0, 16'd32769, 1'b1));
        // Oversized normal clamps the cosine to one
        plan.push_back(row_known(0, 0, 32767, 0, 16'd32769, 1'b1));
        // Zero attenuation leaves ambient alone
        plan.push_back(row_known(0, 0, 16384, 5, RST_AMBIENT, 1'b1));
        plan.push_back(row_shade(0, 0, 16384, 1023));
        // Specular base not positive, then barely positive
        plan.push_back(row_shade(0, 0, 8192, 0));
        plan.push_back(row_shade(0, 0, 11586, 0));
        plan.push_back(row_known(-32768, -32768, -32768, 1023, 16'd0, 1'b0));
        plan.push_back(row_shade(32767, 32767, 32767, 1023));
        // Read right behind the write of the same entry
        plan.push_back(row_write(77, 16'd12345));
        plan.push_back(row_shade(3000, -2000, 15000, 77));
        // Tiny view: cosine truncates to zero, then to one step
        plan.push_back(row_reg(CFG_VIEW_Z, 16'd1));
        plan.push_back(row_known(0, 0, 8191, 0, 16'd0, 1'b0));
        plan.push_back(row_known(0, 0, 8192, 0, RST_AMBIENT, 1'b1));
        // Zero exponent, view longer than unit
        plan.push_back(row_reg(CFG_VIEW_X, 16'(-16384)));
        plan.push_back(row_reg(CFG_VIEW_Z, 16'd16384));
        plan.push_back(row_reg(CFG_SPEC_EXP, 16'd0));
        plan.push_back(row_shade(-16384, 0, 16384, 0));
        plan.push_back(row_shade(0, 0, 11586, 1023));
        // Raw ambient saturates; high exponent bits drop; unmapped index is ignored
        plan.push_back(row_reg(CFG_AMBIENT, 16'hFFFF));
        plan.push_back(row_reg(CFG_SPEC_EXP, 16'hFFFF));
        plan.push_back(row_reg(CFG_UNMAPPED, 16'h1234));
        plan.push_back(row_known(0, 0, 16384, 1023, SHADE_MAX, 1'b1));
        plan.push_back(row_known(0, 0, -16384, 0, 16'd0, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (i == 0 || plan[i - 1].kind != ROW_REG) wait_idle();
                write_reg(plan[i].ridx, plan[i].rval);
            end else begin
                send_word(plan[i].cmd, plan[i].nx, plan[i].ny, plan[i].nz, plan[i].di,
                          plan[i].tv, plan[i].known, plan[i].want);
            end
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++) begin
            tx_quiet = (phase % 3 == 2);
            rx_quiet = (phase % 4 == 3);
            configure_phase(phase);
            repeat (WORDS_PER_PHASE) random_word();
        end

        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/phs_pkg.sv
rtl/core/phs_ram.sv
rtl/core/phs_front.sv
rtl/core/phs_pow_stage.sv
rtl/core/phs_back.sv
rtl/core/phong_shading_intensity_top.sv
rtl/core/phs_checker.sv
tb/testbench.sv
